### rtl/core/piezo_hit_detector_macros.svh
// Assertion macros used by the piezo hit detector controller.
`ifndef PIEZO_HIT_DETECTOR_MACROS_SVH
`define PIEZO_HIT_DETECTOR_MACROS_SVH

// Implication in the same cycle, sampled on clk and disabled during reset.
`define PHD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication in the next cycle.
`define PHD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/phd_pkg.sv
// Package with widths, codes, types and the velocity curve builder of the hit detector.
`timescale 1ns / 1ps
package phd_pkg;
	localparam int SAMPLE_W = 14;
	localparam int LEVEL_W = 13;
	localparam int COUNT_W = 16;
	localparam int DECAY_W = 16;
	localparam int FS_W = 14;
	localparam int VEL_W = 7;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CURVE_ENTRIES_DEF = 2048;
	localparam int CURVE_MAX = 4096;

	localparam logic [63:0] Q_ONE = 64'd1 << 29;
	localparam logic [63:0] Q_HALF = 64'd1 << 28;
	localparam logic [63:0] Q_BASE = 64'd547608330;

	localparam logic [LEVEL_W-1:0] RST_MIN_THRESHOLD = 13'd250;
	localparam logic [COUNT_W-1:0] RST_SCAN_LENGTH = 16'd160;
	localparam logic [COUNT_W-1:0] RST_MASK_LENGTH = 16'd320;
	localparam logic [DECAY_W-1:0] RST_DECAY_FACTOR = 16'd65396;
	localparam logic [FS_W-1:0] RST_FULL_SCALE = 14'd13000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MIN_THRESHOLD,
		REG_SCAN_LENGTH,
		REG_MASK_LENGTH,
		REG_DECAY_FACTOR,
		REG_FULL_SCALE
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECAY,
		ST_EVAL,
		ST_START,
		ST_DIV,
		ST_LOOK,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load_sample;
		logic decay;
		logic eval;
		logic div_start;
		logic look;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic div_busy;
		logic out_free;
	} status_t;

	function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
		return (a * b + Q_HALF) >> 29;
	endfunction

	// Builds the rounded exponential curve, seven bits per entry, entry 0 lowest.
	function automatic logic [CURVE_MAX*VEL_W-1:0] build_curve(int unsigned entries);
		logic [63:0] whole [127];
		logic [63:0] part [CURVE_MAX/128];
		logic [63:0] lo, hi, mid, p, span, e, num, val, k;
		logic [CURVE_MAX*VEL_W-1:0] bits;
		logic [VEL_W-1:0] v;
		int unsigned s, i, j, n, f, q;
		s = entries / 128;
		bits = '0;
		lo = Q_ONE;
		hi = Q_BASE;
		while (lo < hi) begin
			mid = (lo + hi + 64'd1) >> 1;
			p = Q_ONE;
			for (j = 0; j < s; j++)
				p = qmul(p, mid);
			if (p <= Q_BASE)
				lo = mid;
			else
				hi = mid - 64'd1;
		end
		part[0] = Q_ONE;
		for (i = 1; i < s; i++)
			part[i] = qmul(part[i-1], lo);
		whole[0] = Q_ONE;
		for (i = 1; i < 127; i++)
			whole[i] = qmul(whole[i-1], Q_BASE);
		span = whole[126] - Q_ONE;
		for (n = 0; n < 127; n++) begin
			for (f = 0; f < s; f++) begin
				if (n < 126 || f == 0) begin
					e = qmul(whole[n], part[f]);
					num = (e > Q_ONE) ? e - Q_ONE : 64'd0;
					val = 64'd252 * num + span;
					k = 64'd0;
					while ((k + 64'd1) * 64'd2 * span <= val)
						k = k + 64'd1;
					v = VEL_W'(k + 64'd1);
					q = s + n * s + f;
					bits[q*VEL_W +: VEL_W] = v;
					if (n == 0 && f == 0)
						for (j = 0; j < s; j++)
							bits[j*VEL_W +: VEL_W] = v;
					if (n == 126)
						for (j = q + 1; j < entries; j++)
							bits[j*VEL_W +: VEL_W] = v;
				end
			end
		end
		return bits;
	endfunction
endpackage

### rtl/core/phd_sample_if.sv
// Input channel carrying one converter sample per item.
`timescale 1ns / 1ps
interface phd_sample_if import phd_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

### rtl/core/phd_hit_if.sv
// Output channel carrying one finished hit per item.
`timescale 1ns / 1ps
interface phd_hit_if import phd_pkg::*; ();
	logic valid;
	logic ready;
	logic [LEVEL_W-1:0] peak;
	logic [VEL_W-1:0] velocity;

	modport source (output valid, output peak, output velocity, input ready);
	modport sink (input valid, input peak, input velocity, output ready);
endinterface

### rtl/core/phd_div.sv
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module phd_div #(
	parameter int NUM_W = 25,
	parameter int DEN_W = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quot
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_q;
	logic [NUM_W-1:0] quot_q;
	logic [DEN_W+1:0] trial;
	logic             fits;

	assign trial = {rem_q, quot_q[NUM_W-1]};
	assign fits = trial >= {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NUM_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quot_q <= num;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? (DEN_W+1)'(trial - {2'b00, den_q}) : (DEN_W+1)'(trial);
			quot_q <= {quot_q[NUM_W-2:0], fits};
		end
	end

	assign busy = cnt_q != '0;
	assign quot = quot_q;
endmodule

### rtl/core/phd_ctrl.sv
// Controller state machine sequencing the per-item steps of the hit detector.
`timescale 1ns / 1ps
`include "piezo_hit_detector_macros.svh"
module phd_ctrl import phd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_sample = 1'b1;
					state_d = ST_DECAY;
				end
			end
			ST_DECAY: begin
				cmd.decay = 1'b1;
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d = status.scan_done ? ST_START : ST_IDLE;
			end
			ST_START: begin
				cmd.div_start = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (!status.div_busy) state_d = ST_LOOK;
			end
			ST_LOOK: begin
				cmd.look = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`PHD_ASSERT_NEXT(a_accept_to_decay, in_valid && in_ready, state_q == ST_DECAY, "item accepted but no decay step followed")
	`PHD_ASSERT_IMPL(a_load_when_free, cmd.load_out, status.out_free, "result loaded over an unread result")
	`PHD_ASSERT_NEXT(a_start_busy, cmd.div_start, status.div_busy, "divider did not start")
endmodule

### rtl/core/phd_dp.sv
// Datapath: configuration, detector state, decay multiplier, divider, curve and result register.
`timescale 1ns / 1ps
module phd_dp import phd_pkg::*; #(
	parameter int CURVE_ENTRIES = CURVE_ENTRIES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic [SAMPLE_W-1:0]    in_sample,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [LEVEL_W-1:0]     out_peak,
	output logic [VEL_W-1:0]       out_velocity,
	input  cmd_t                   cmd,
	output status_t                status
);
	localparam int S = CURVE_ENTRIES / 128;
	localparam int AW = $clog2(CURVE_ENTRIES);
	localparam int NUM_W = LEVEL_W + $clog2(CURVE_ENTRIES + 1);
	localparam logic [CURVE_MAX*VEL_W-1:0] CURVE_BITS = build_curve(CURVE_ENTRIES);

	logic [LEVEL_W-1:0] thr_q;
	logic [COUNT_W-1:0] scan_len_q, mask_len_q;
	logic [DECAY_W-1:0] decay_q;
	logic [FS_W-1:0]    fs_q;

	logic               scanning_q;
	logic [LEVEL_W-1:0] samp_q, peak_q, last_peak_q, mask_q;
	logic [COUNT_W-1:0] scan_cnt_q, mask_cnt_q;
	logic [VEL_W-1:0]   vel_q;
	logic               out_valid_q;
	logic [LEVEL_W-1:0] out_peak_q;
	logic [VEL_W-1:0]   out_vel_q;

	logic [LEVEL_W+DECAY_W-1:0] prod;
	logic               in_window, onset, div_busy;
	logic [COUNT_W-1:0] scan_cnt_nx;
	logic [LEVEL_W-1:0] peak_nx;
	logic [NUM_W-1:0]   num, quot;
	logic [FS_W-1:0]    den;
	logic [AW-1:0]      addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= RST_MIN_THRESHOLD;
			scan_len_q <= RST_SCAN_LENGTH;
			mask_len_q <= RST_MASK_LENGTH;
			decay_q <= RST_DECAY_FACTOR;
			fs_q <= RST_FULL_SCALE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_THRESHOLD: thr_q <= cfg_data[LEVEL_W-1:0];
				REG_SCAN_LENGTH: scan_len_q <= cfg_data;
				REG_MASK_LENGTH: mask_len_q <= cfg_data;
				REG_DECAY_FACTOR: decay_q <= cfg_data;
				REG_FULL_SCALE: fs_q <= cfg_data[FS_W-1:0];
				default: ;
			endcase
		end
	end

	assign prod = mask_q * decay_q;
	assign in_window = mask_cnt_q < mask_len_q;
	assign scan_cnt_nx = scan_cnt_q + 1'b1;
	assign peak_nx = (samp_q > peak_q) ? samp_q : peak_q;
	always_comb begin
		if (in_window)
			onset = {samp_q, 1'b0} > ({2'b00, last_peak_q} + {1'b0, last_peak_q, 1'b0});
		else
			onset = {1'b0, samp_q} > ({1'b0, thr_q} + {1'b0, mask_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scanning_q <= 1'b0;
			peak_q <= '0;
			last_peak_q <= '0;
			mask_q <= '0;
			scan_cnt_q <= '0;
			mask_cnt_q <= '0;
		end else if (cmd.decay) begin
			if (!scanning_q && !in_window && mask_q != '0) mask_q <= prod[DECAY_W +: LEVEL_W];
		end else if (cmd.eval) begin
			if (!scanning_q) begin
				if (in_window) begin
					mask_cnt_q <= mask_cnt_q + 1'b1;
					if (samp_q > mask_q) mask_q <= samp_q;
				end
				if (onset) begin
					scan_cnt_q <= '0;
					peak_q <= samp_q;
					scanning_q <= 1'b1;
				end
			end else begin
				if (samp_q > peak_q) mask_q <= samp_q;
				peak_q <= peak_nx;
				scan_cnt_q <= scan_cnt_nx;
				if (scan_cnt_nx >= scan_len_q) begin
					last_peak_q <= peak_nx;
					mask_cnt_q <= '0;
					scanning_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_sample) samp_q <= in_sample[SAMPLE_W-1] ? '0 : in_sample[LEVEL_W-1:0];
	end

	assign num = NUM_W'(last_peak_q - thr_q) * NUM_W'(CURVE_ENTRIES);
	assign den = fs_q - FS_W'(thr_q);

	phd_div #(.NUM_W(NUM_W), .DEN_W(FS_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(num), .den(den), .busy(div_busy), .quot(quot)
	);

	always_comb begin
		priority if (last_peak_q <= thr_q)
			addr = AW'(S);
		else if (fs_q <= FS_W'(thr_q))
			addr = AW'(127 * S);
		else if (quot < NUM_W'(S))
			addr = AW'(S);
		else if (quot > NUM_W'(127 * S))
			addr = AW'(127 * S);
		else
			addr = quot[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.look) vel_q <= CURVE_BITS[int'(addr)*VEL_W +: VEL_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_peak_q <= last_peak_q;
			out_vel_q <= vel_q;
		end
	end

	assign status.scan_done = scanning_q && (scan_cnt_nx >= scan_len_q);
	assign status.div_busy = div_busy;
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_peak = out_peak_q;
	assign out_velocity = out_vel_q;
endmodule

### rtl/core/piezo_hit_detector.sv
// Top level of the piezo hit detector: controller, datapath and channel wiring.
`timescale 1ns / 1ps
// Each sample is accepted, then passes through the mask decay (one multiplier) and the state update.
// A sample that ends a scan then starts the divider, runs the serial velocity divider, reads the
// curve and loads the result register, after any wait for the previous result to be taken; the
// next sample may be accepted while that result waits to be taken.
// There is no clearing pass after reset; the curve is a constant table.
module piezo_hit_detector import phd_pkg::*; #(
	parameter int CURVE_ENTRIES = CURVE_ENTRIES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	phd_sample_if.sink             samples,
	phd_hit_if.source              hits
);
	cmd_t    cmd;
	status_t status;

	phd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(samples.valid),
		.in_ready(samples.ready), .status(status), .cmd(cmd)
	);

	phd_dp #(.CURVE_ENTRIES(CURVE_ENTRIES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_sample(samples.sample), .out_ready(hits.ready),
		.out_valid(hits.valid), .out_peak(hits.peak), .out_velocity(hits.velocity),
		.cmd(cmd), .status(status)
	);
endmodule
